### src/pwbnr_pkg.sv
// ----------------------------------------------------------------------------
// pwbnr_pkg
// Shared types and constants for the pulse-width bus nibble receiver.
// ----------------------------------------------------------------------------
package pwbnr_pkg;

   // Capacity of one packet in nibbles, checksum included
   localparam logic [5:0] MAX_NIBBLES = 6'd32;

   // Register reset values
   localparam logic [15:0] SAMPLE_DELAY_RESET = 16'd800;
   localparam logic [15:0] GAP_TIMEOUT_RESET  = 16'd4500;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_SAMPLE_DELAY = 1'b0,
      CSR_GAP_TIMEOUT  = 1'b1
   } csr_index_type;

   // Events of one tick, from the timing logic to the nibble assembler
   typedef struct packed {
      logic sample_hit;
      logic level;
      logic ending;
   } tick_type;

   // One result beat
   typedef struct packed {
      logic [3:0] nibble_value;
      logic       nibble_valid;
      logic       end_of_packet;
      logic       checksum_ok;
      logic [5:0] packet_nibbles;
      logic       overflow;
   } result_type;

endpackage

### src/pwbnr_nibble.sv
// ----------------------------------------------------------------------------
// pwbnr_nibble
// Bit-to-nibble assembly, packet capacity and checksum tracking.
// ----------------------------------------------------------------------------
module pwbnr_nibble (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  pwbnr_pkg::tick_type  tick,
   output logic                 result_valid,
   output pwbnr_pkg::result_type result
);

   logic [3:0] bit_shift_ff, bit_shift_in;
   logic [1:0] bit_phase_ff, bit_phase_in;
   logic [5:0] nibble_count_ff, nibble_count_in;
   logic [3:0] xor_accum_ff, xor_accum_in;
   logic [3:0] last_nibble_ff, last_nibble_in;
   logic       overflow_ff, overflow_in;

   logic [3:0] shifted;
   logic [3:0] mid_shift;
   logic [1:0] mid_phase;
   logic       complete;
   logic       cand_valid;
   logic [3:0] cand_nibble;
   logic [3:0] padded;
   logic       kept;
   logic [3:0] xor_next;
   logic [3:0] last_next;
   logic [5:0] count_next;
   logic       ovf_next;
   logic [3:0] xor_plus;

   // Shift in the sampled bit, MSB first
   always_comb begin
      shifted   = {bit_shift_ff[2:0], tick.level};
      complete  = 1'b0;
      mid_shift = bit_shift_ff;
      mid_phase = bit_phase_ff;
      if (tick.sample_hit) begin
         if (bit_phase_ff == 2'd3) begin
            complete  = 1'b1;
            mid_shift = 4'd0;
            mid_phase = 2'd0;
         end else begin
            mid_shift = shifted;
            mid_phase = bit_phase_ff + 2'd1;
         end
      end
   end

   // Pad a partial nibble with zeros at the end of a packet
   always_comb begin
      case (mid_phase)
         2'd1:    padded = {mid_shift[0], 3'b000};
         2'd2:    padded = {mid_shift[1:0], 2'b00};
         2'd3:    padded = {mid_shift[2:0], 1'b0};
         default: padded = mid_shift;
      endcase
   end

   // Pick the nibble candidate of this tick, at most one
   always_comb begin
      cand_valid  = complete || (tick.ending && (mid_phase != 2'd0));
      cand_nibble = complete ? shifted : padded;
   end

   // Keep the candidate if capacity allows, else flag overflow
   always_comb begin
      kept       = 1'b0;
      xor_next   = xor_accum_ff;
      last_next  = last_nibble_ff;
      count_next = nibble_count_ff;
      ovf_next   = overflow_ff;
      if (cand_valid) begin
         if (nibble_count_ff >= pwbnr_pkg::MAX_NIBBLES) begin
            ovf_next = 1'b1;
         end else begin
            kept = 1'b1;
            if (nibble_count_ff != 6'd0) begin
               xor_next = xor_accum_ff ^ last_nibble_ff;
            end
            last_next  = cand_nibble;
            count_next = nibble_count_ff + 6'd1;
         end
      end
      xor_plus = xor_next + 4'd1;
   end

   // Build the result beat
   always_comb begin
      result       = '0;
      result_valid = tick.ending || kept;
      if (kept) begin
         result.nibble_value = cand_nibble;
         result.nibble_valid = 1'b1;
      end
      if (tick.ending) begin
         result.end_of_packet  = 1'b1;
         result.checksum_ok    = (count_next >= 6'd2) && (xor_plus == last_next);
         result.packet_nibbles = count_next;
         result.overflow       = ovf_next;
      end
   end

   // Advance packet state; clear it when the packet ends
   always_comb begin
      if (tick.ending) begin
         bit_shift_in    = 4'd0;
         bit_phase_in    = 2'd0;
         nibble_count_in = 6'd0;
         xor_accum_in    = 4'd0;
         last_nibble_in  = 4'd0;
         overflow_in     = 1'b0;
      end else begin
         bit_shift_in    = mid_shift;
         bit_phase_in    = mid_phase;
         nibble_count_in = count_next;
         xor_accum_in    = xor_next;
         last_nibble_in  = last_next;
         overflow_in     = ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_shift_ff    <= 4'd0;
         bit_phase_ff    <= 2'd0;
         nibble_count_ff <= 6'd0;
         xor_accum_ff    <= 4'd0;
         last_nibble_ff  <= 4'd0;
         overflow_ff     <= 1'b0;
      end else if (step) begin
         bit_shift_ff    <= bit_shift_in;
         bit_phase_ff    <= bit_phase_in;
         nibble_count_ff <= nibble_count_in;
         xor_accum_ff    <= xor_accum_in;
         last_nibble_ff  <= last_nibble_in;
         overflow_ff     <= overflow_in;
      end
   end

   // Kept nibble count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      nibble_count_ff <= pwbnr_pkg::MAX_NIBBLES)
      else $error("nibble count above capacity");

   // Partial bits are only held while the packet state is live
   a_phase_cleared: assert property (@(posedge clock) disable iff (reset)
      step && tick.ending |=> bit_phase_ff == 2'd0 && nibble_count_ff == 6'd0)
      else $error("packet state not cleared at end");

   // Overflow can only be flagged with a full packet
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> nibble_count_ff == pwbnr_pkg::MAX_NIBBLES)
      else $error("overflow without full packet");

endmodule

### src/pulse_width_bus_nibble_receiver.sv
// ----------------------------------------------------------------------------
// pulse_width_bus_nibble_receiver
// Each accepted beat is one tick of the bus line. A rising edge (while the own
// transmitter is off) restarts the idle-gap timer and, if no sample is
// pending, arms a sample timer of sample_delay ticks; at its expiry the line
// level is shifted in MSB first and every fourth bit yields a nibble beat.
// When gap_timeout ticks pass without an edge, an end beat reports any padded
// partial nibble, the nibble count, overflow and the checksum verdict. One
// tick is taken every clock cycle unless the output stalls. A tick is held in
// the input register and its result is loaded into the result register, from
// which the beat is offered; the whole state update is done in the single
// stage between the two registers. While a result beat waits on rsp_ready,
// the input stalls. Ticks that cause no result produce no output beat.
// Configuration writes take effect at the next arming.
// ----------------------------------------------------------------------------
module pulse_width_bus_nibble_receiver (
   input  logic        clock,
   input  logic        reset,
   // tick channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_line_level,
   input  logic        req_transmit_active,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_nibble_value,
   output logic        rsp_nibble_valid,
   output logic        rsp_end_of_packet,
   output logic        rsp_checksum_ok,
   output logic [5:0]  rsp_packet_nibbles,
   output logic        rsp_overflow,
   // configuration
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic        in_valid_ff, in_valid_in;
   logic        in_level_ff;
   logic        in_tx_ff;
   logic [15:0] sample_delay_ff;
   logic [15:0] gap_timeout_ff;
   logic        prev_level_ff;
   logic [15:0] sample_cnt_ff, sample_cnt_in;
   logic [15:0] gap_cnt_ff, gap_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pwbnr_pkg::result_type rsp_ff;

   logic                  advance;
   logic                  accept;
   logic [15:0]           sample_dec;
   logic [15:0]           gap_dec;
   logic                  rise;
   logic [15:0]           sample_load;
   logic [15:0]           gap_load;
   pwbnr_pkg::tick_type   tick;
   logic                  res_valid;
   pwbnr_pkg::result_type res;

   // Handshake: process the held tick when the result register can take a beat
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_level_ff <= req_line_level;
         in_tx_ff    <= req_transmit_active;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_delay_ff <= pwbnr_pkg::SAMPLE_DELAY_RESET;
         gap_timeout_ff  <= pwbnr_pkg::GAP_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pwbnr_pkg::CSR_SAMPLE_DELAY: sample_delay_ff <= csr_write_data;
            pwbnr_pkg::CSR_GAP_TIMEOUT:  gap_timeout_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Step both countdowns, then rearm on a rising edge
   always_comb begin
      sample_dec  = (sample_cnt_ff != 16'd0) ? sample_cnt_ff - 16'd1 : 16'd0;
      gap_dec     = (gap_cnt_ff != 16'd0) ? gap_cnt_ff - 16'd1 : 16'd0;
      rise        = in_level_ff && !prev_level_ff && !in_tx_ff;
      sample_load = (sample_delay_ff != 16'd0) ? sample_delay_ff : 16'd1;
      gap_load    = (gap_timeout_ff != 16'd0) ? gap_timeout_ff : 16'd1;

      tick.sample_hit = (sample_cnt_ff == 16'd1);
      tick.level      = in_level_ff;
      tick.ending     = (gap_cnt_ff == 16'd1);

      sample_cnt_in = (rise && sample_dec == 16'd0) ? sample_load : sample_dec;
      gap_cnt_in    = rise ? gap_load : gap_dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         sample_cnt_ff <= 16'd0;
         gap_cnt_ff    <= 16'd0;
      end else if (advance) begin
         prev_level_ff <= in_level_ff;
         sample_cnt_ff <= sample_cnt_in;
         gap_cnt_ff    <= gap_cnt_in;
      end
   end

   pwbnr_nibble u_nibble (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .tick         (tick),
      .result_valid (res_valid),
      .result       (res)
   );

   // Result register
   always_comb begin
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_nibble_value   = rsp_ff.nibble_value;
   assign rsp_nibble_valid   = rsp_ff.nibble_valid;
   assign rsp_end_of_packet  = rsp_ff.end_of_packet;
   assign rsp_checksum_ok    = rsp_ff.checksum_ok;
   assign rsp_packet_nibbles = rsp_ff.packet_nibbles;
   assign rsp_overflow       = rsp_ff.overflow;

   // A beat that is not an end beat always carries a nibble
   a_mid_has_nibble: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.end_of_packet |-> rsp_ff.nibble_valid)
      else $error("non-end beat without nibble");

   // End-only fields stay zero on nibble beats
   a_mid_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.end_of_packet |->
         !rsp_ff.checksum_ok && !rsp_ff.overflow && rsp_ff.packet_nibbles == 6'd0)
      else $error("end fields set on nibble beat");

   // Checksum can only pass with at least two nibbles
   a_ok_needs_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.checksum_ok |-> rsp_ff.packet_nibbles >= 6'd2)
      else $error("checksum ok on short packet");

   // A result beat can only be loaded by a processed tick
   a_load_from_tick: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(advance))
      else $error("result beat without processed tick");

endmodule
